### design/lcg48_random_generator_defines.svh
// Assertion macros shared by the generator modules.
`ifndef LCG48_RANDOM_GENERATOR_DEFINES_SVH
`define LCG48_RANDOM_GENERATOR_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define LCG48_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("Same-cycle check failed.");
`define LCG48_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("Next-cycle check failed.");
`else
`define LCG48_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define LCG48_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

### design/lcg48_pkg.sv
package lcg48_pkg;

   localparam int STATE_W = 48;
   localparam int INT_BITS = 31;
   localparam int VALUE_W = 53;
   localparam int COUNT_W = 6;
   localparam int MULT_W = 35;

   localparam logic [MULT_W-1:0] LCG_MULT = 35'h5DEECE66D;
   localparam logic [STATE_W-1:0] LCG_ADD = 48'hB;

   typedef enum logic [1:0] {
      CMD_RESEED      = 2'd0,
      CMD_NEXT_BITS   = 2'd1,
      CMD_BOUNDED_INT = 2'd2,
      CMD_DOUBLE      = 2'd3
   } cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

### design/lcg48_channels.sv
interface lcg48_req_if;
   import lcg48_pkg::*;

   logic                valid;
   logic                ready;
   cmd_type             cmd;
   logic [STATE_W-1:0]  seed_value;
   logic [COUNT_W-1:0]  bit_count;
   logic [INT_BITS-1:0] bound;

   modport source (output valid, output cmd, output seed_value, output bit_count,
                   output bound, input ready);
   modport sink (input valid, input cmd, input seed_value, input bit_count,
                 input bound, output ready);
endinterface

interface lcg48_rsp_if;
   import lcg48_pkg::*;

   logic               valid;
   logic               ready;
   logic [VALUE_W-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink (input valid, input value, output ready);
endinterface

### design/lcg48_mod_unit.sv
`include "lcg48_random_generator_defines.svh"

module lcg48_mod_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [lcg48_pkg::INT_BITS-1:0] dividend,
   input  logic [lcg48_pkg::INT_BITS-1:0] divisor,
   output lcg48_pkg::div_status_type     status,
   output logic [lcg48_pkg::INT_BITS-1:0] remainder
);
   import lcg48_pkg::*;

   localparam int CNT_W = $clog2(INT_BITS + 1);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [INT_BITS-1:0] rem_ff, rem_in;
   logic [INT_BITS-1:0] dvd_ff, dvd_in;
   logic [INT_BITS-1:0] div_ff, div_in;
   logic [INT_BITS:0]   rem_shift;
   logic [INT_BITS+1:0] diff;

   assign rem_shift = {rem_ff, dvd_ff[INT_BITS-1]};
   assign diff = {1'b0, rem_shift} - {2'b00, div_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in = cnt_ff;
      rem_in = rem_ff;
      dvd_in = dvd_ff;
      div_in = div_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in = CNT_W'(INT_BITS);
         rem_in = '0;
         dvd_in = dividend;
         div_in = divisor;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[INT_BITS-2:0], 1'b0};
         rem_in = diff[INT_BITS+1] ? rem_shift[INT_BITS-1:0] : diff[INT_BITS-1:0];
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      div_ff <= div_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign remainder = rem_ff;

   `LCG48_ASSERT_IMPLIES(a_done_rem_below, clock, reset, done_ff, rem_ff < div_ff)
   `LCG48_ASSERT_NEXT(a_start_busy, clock, reset, start, busy_ff && cnt_ff == CNT_W'(INT_BITS))
   `LCG48_ASSERT_IMPLIES(a_busy_count, clock, reset, busy_ff, cnt_ff != '0 && !done_ff)

endmodule

### design/lcg48_random_generator.sv
// Reseed loads the scrambled seed; next bits takes one generator step, double two,
// a power-of-two bound one step and a scale multiply, other bounds one step and one
// remainder per candidate. A generator step runs MUL_LO, MUL_HI and STEP on the shared
// 32x35 multiplier; the 31-step remainder unit runs for each bounded-int candidate.
// Input ready is high only while idle, so each request finishes before the next is accepted.
// Synchronous reset loads the state with the scrambled seed zero.
`include "lcg48_random_generator_defines.svh"

module lcg48_random_generator (
   input  logic        clock,
   input  logic        reset,
   lcg48_req_if.sink   req_if,
   lcg48_rsp_if.source rsp_if
);
   import lcg48_pkg::*;

   localparam int MUL_A_W = 32;
   localparam int PROD_W = MUL_A_W + MULT_W;
   localparam int HALF_W = STATE_W / 2;

   typedef enum logic [8:0] {
      ST_IDLE      = 9'b000000001,
      ST_MUL_LO    = 9'b000000010,
      ST_MUL_HI    = 9'b000000100,
      ST_STEP      = 9'b000001000,
      ST_PICK      = 9'b000010000,
      ST_DIVIDE    = 9'b000100000,
      ST_SCALE     = 9'b001000000,
      ST_SCALE_OUT = 9'b010000000,
      ST_DONE      = 9'b100000000
   } fsm_type;

   fsm_type fsm_ff, fsm_in;
   logic [STATE_W-1:0]  lcg_state_ff, lcg_state_in;
   logic [STATE_W-1:0]  acc_ff;
   logic [PROD_W-1:0]   prod_ff, prod_in;
   cmd_type             cmd_ff, cmd_in;
   logic [COUNT_W-1:0]  bit_count_ff, bit_count_in;
   logic [INT_BITS-1:0] bound_ff, bound_in;
   logic [INT_BITS-1:0] r_ff, r_in;
   logic [25:0]         hi_ff, hi_in;
   logic                phase_ff, phase_in;
   logic [VALUE_W-1:0]  res_ff, res_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0]  value_ff, value_in;

   logic [MUL_A_W-1:0]  mul_a;
   logic [MULT_W-1:0]   mul_b;
   logic                req_accept;
   logic                slot_free;
   logic                bound_pow2;
   logic [COUNT_W-1:0]  eff_bits;
   logic [COUNT_W-1:0]  shamt;
   logic [31:0]         top_bits;
   logic [31:0]         t_check;
   logic                reject;
   logic                div_start;
   div_status_type      div_status;
   logic [INT_BITS-1:0] div_rem;

   assign req_accept = req_if.valid && req_if.ready;
   assign req_if.ready = (fsm_ff == ST_IDLE);
   assign slot_free = !rsp_valid_ff || rsp_if.ready;

   always_comb begin
      unique case (fsm_ff)
         ST_MUL_HI: begin
            mul_a = MUL_A_W'(lcg_state_ff[STATE_W-1:HALF_W]);
            mul_b = LCG_MULT;
         end
         ST_SCALE: begin
            mul_a = MUL_A_W'(bound_ff);
            mul_b = MULT_W'(r_ff);
         end
         default: begin
            mul_a = MUL_A_W'(lcg_state_ff[HALF_W-1:0]);
            mul_b = LCG_MULT;
         end
      endcase
   end

   assign prod_in = PROD_W'(mul_a) * PROD_W'(mul_b);

   assign bound_pow2 = (bound_ff & (~bound_ff + INT_BITS'(1))) == bound_ff;
   assign eff_bits = (bit_count_ff > COUNT_W'(32)) ? COUNT_W'(32) : bit_count_ff;
   assign shamt = COUNT_W'(32) - eff_bits;
   assign top_bits = lcg_state_ff[STATE_W-1:STATE_W-32] >> shamt;
   assign t_check = {1'b0, r_ff} - {1'b0, div_rem} + {1'b0, bound_ff} - 32'd1;
   assign reject = t_check[31];
   assign div_start = (fsm_ff == ST_PICK) && (cmd_ff == CMD_BOUNDED_INT) && !bound_pow2;

   lcg48_mod_unit u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (lcg_state_ff[STATE_W-1:STATE_W-INT_BITS]),
      .divisor   (bound_ff),
      .status    (div_status),
      .remainder (div_rem)
   );

   always_comb begin
      fsm_in = fsm_ff;
      lcg_state_in = lcg_state_ff;
      cmd_in = cmd_ff;
      bit_count_in = bit_count_ff;
      bound_in = bound_ff;
      r_in = r_ff;
      hi_in = hi_ff;
      phase_in = phase_ff;
      res_in = res_ff;
      unique case (fsm_ff)
         ST_IDLE: begin
            if (req_accept) begin
               cmd_in = req_if.cmd;
               bit_count_in = req_if.bit_count;
               bound_in = req_if.bound;
               phase_in = 1'b0;
               if (req_if.cmd == CMD_RESEED) begin
                  lcg_state_in = req_if.seed_value ^ STATE_W'(LCG_MULT);
                  res_in = '0;
                  fsm_in = ST_DONE;
               end else begin
                  fsm_in = ST_MUL_LO;
               end
            end
         end
         ST_MUL_LO: fsm_in = ST_MUL_HI;
         ST_MUL_HI: fsm_in = ST_STEP;
         ST_STEP: begin
            lcg_state_in = acc_ff + {prod_ff[HALF_W-1:0], {HALF_W{1'b0}}};
            fsm_in = ST_PICK;
         end
         ST_PICK: begin
            r_in = lcg_state_ff[STATE_W-1:STATE_W-INT_BITS];
            case (cmd_ff)
               CMD_NEXT_BITS: begin
                  res_in = (bit_count_ff == '0) ? '0 : VALUE_W'(top_bits);
                  fsm_in = ST_DONE;
               end
               CMD_BOUNDED_INT: fsm_in = bound_pow2 ? ST_SCALE : ST_DIVIDE;
               default: begin
                  if (!phase_ff) begin
                     hi_in = lcg_state_ff[STATE_W-1:STATE_W-26];
                     phase_in = 1'b1;
                     fsm_in = ST_MUL_LO;
                  end else begin
                     res_in = {hi_ff, lcg_state_ff[STATE_W-1:STATE_W-27]};
                     fsm_in = ST_DONE;
                  end
               end
            endcase
         end
         ST_DIVIDE: begin
            if (div_status.done) begin
               if (reject) begin
                  fsm_in = ST_MUL_LO;
               end else begin
                  res_in = VALUE_W'(div_rem);
                  fsm_in = ST_DONE;
               end
            end
         end
         ST_SCALE: fsm_in = ST_SCALE_OUT;
         ST_SCALE_OUT: begin
            res_in = VALUE_W'(prod_ff[2*INT_BITS-1:INT_BITS]);
            fsm_in = ST_DONE;
         end
         ST_DONE: begin
            if (slot_free) begin
               fsm_in = ST_IDLE;
            end
         end
         default: fsm_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      value_in = value_ff;
      if (fsm_ff == ST_DONE && slot_free) begin
         rsp_valid_in = 1'b1;
         value_in = res_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fsm_ff <= ST_IDLE;
         lcg_state_ff <= STATE_W'(LCG_MULT);
         phase_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fsm_ff <= fsm_in;
         lcg_state_ff <= lcg_state_in;
         phase_ff <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      acc_ff <= prod_ff[STATE_W-1:0] + LCG_ADD;
      prod_ff <= prod_in;
      cmd_ff <= cmd_in;
      bit_count_ff <= bit_count_in;
      bound_ff <= bound_in;
      r_ff <= r_in;
      hi_ff <= hi_in;
      res_ff <= res_in;
      value_ff <= value_in;
   end

   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.value = value_ff;

   `LCG48_ASSERT_NEXT(a_reseed_load, clock, reset,
      req_accept && req_if.cmd == CMD_RESEED,
      lcg_state_ff == $past(req_if.seed_value ^ STATE_W'(LCG_MULT)))
   `LCG48_ASSERT_IMPLIES(a_accept_rem_below, clock, reset,
      fsm_ff == ST_DIVIDE && div_status.done && !reject, div_rem < bound_ff)
   `LCG48_ASSERT_IMPLIES(a_div_start_bound, clock, reset,
      div_start, bound_ff != '0 && !div_status.busy)

endmodule
